// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rsc_pkg.sv =====
package rsc_pkg;

	localparam int VALUE_W         = 32;
	localparam int OP_W            = 3;
	localparam int ERR_W           = 3;
	localparam int OUT_DEPTH_W     = 8;
	localparam int STACK_DEPTH_DEF = 128;

	typedef enum logic [OP_W-1:0] {
		OP_INIT     = 3'd0,
		OP_PUSH     = 3'd1,
		OP_ADD      = 3'd2,
		OP_NEGATE   = 3'd3,
		OP_MULTIPLY = 3'd4,
		OP_POP      = 3'd5,
		OP_RELEASE  = 3'd6
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 3'd0,
		ERR_NOT_INIT = 3'd1,
		ERR_BINARY   = 3'd2,
		ERR_UNARY    = 3'd3,
		ERR_OVERFLOW = 3'd4,
		ERR_POP      = 3'd5,
		ERR_FULL     = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT
	} cell_cmd_t;

	typedef struct packed {
		logic                      ovf;
		logic signed [VALUE_W-1:0] result;
	} alu_out_t;

endpackage

// ===== rtl/rsc_cell.sv =====
module rsc_cell
	import rsc_pkg::*;
(
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic signed [VALUE_W-1:0] prev_value,
	input  logic signed [VALUE_W-1:0] next_value,
	output logic signed [VALUE_W-1:0] value
);

	logic signed [VALUE_W-1:0] value_q;

	// prev is the neighbor toward the top, next the one deeper down
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_FROM_PREV: value_q <= prev_value;
			CELL_FROM_NEXT: value_q <= next_value;
			default:        value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ===== rtl/rsc_alu.sv =====
module rsc_alu
	import rsc_pkg::*;
(
	input  op_t                         op,
	input  logic signed [VALUE_W-1:0]   a,
	input  logic signed [VALUE_W-1:0]   b,
	input  logic signed [2*VALUE_W-1:0] prod,
	output alu_out_t                    res
);

	localparam logic signed [VALUE_W-1:0] MAX_V = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] MIN_V = {1'b1, {(VALUE_W-1){1'b0}}};

	logic signed [VALUE_W:0]     sum;
	logic signed [VALUE_W:0]     neg;
	logic signed [2*VALUE_W-1:0] shifted;

	always_comb begin
		sum     = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
		neg     = -{a[VALUE_W-1], a};
		// arithmetic shift is floor division by 2^16
		shifted = prod >>> 16;
		res.ovf    = 1'b0;
		res.result = a;
		case (op)
			OP_ADD: begin
				if (sum[VALUE_W] != sum[VALUE_W-1]) begin
					res.ovf    = 1'b1;
					res.result = sum[VALUE_W] ? MIN_V : MAX_V;
				end else begin
					res.result = sum[VALUE_W-1:0];
				end
			end
			OP_NEGATE: begin
				if (neg[VALUE_W] != neg[VALUE_W-1]) begin
					res.ovf    = 1'b1;
					res.result = neg[VALUE_W] ? MIN_V : MAX_V;
				end else begin
					res.result = neg[VALUE_W-1:0];
				end
			end
			OP_MULTIPLY: begin
				if (shifted[2*VALUE_W-1:VALUE_W-1] != {(VALUE_W+1){shifted[VALUE_W-1]}}) begin
					res.ovf    = 1'b1;
					res.result = shifted[2*VALUE_W-1] ? MIN_V : MAX_V;
				end else begin
					res.result = shifted[VALUE_W-1:0];
				end
			end
			default: begin
				res.ovf    = 1'b0;
				res.result = a;
			end
		endcase
	end

endmodule

// ===== rtl/rpn_stack_calculator_unit.sv =====
// rpn stack calculator on signed q16.16 values
// input channel: in_valid / in_ready carry req_type and push_value, one
// operation per beat. output channel: out_valid / out_ready carry one result
// beat per operation: pop_value, the sticky error_code and stack_depth.
// the stack is a row of shift cells, top of stack in the first cell; push
// shifts the row down, pop and binary ops shift it up. the accepting edge
// captures the operation, the push value and the product of the top two
// cells in a product register between them and the saturation logic; the
// update state then writes the cells, depth, error and result registers.
// only one operation is in flight; in_ready is low during the update cycle.
// when the receiver stalls, the update cycle waits until the pending result
// is taken, so results are never overwritten or dropped.
// reset: not initialized, depth zero, error ok, no result pending. stack cell
// contents are not cleared; no operation reads an entry it has not written.
module rpn_stack_calculator_unit
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic        [OP_W-1:0]        req_type,
	input  logic signed [VALUE_W-1:0]     push_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_W-1:0]     pop_value,
	output logic        [ERR_W-1:0]       error_code,
	output logic        [OUT_DEPTH_W-1:0] stack_depth
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] FULL_D = DW'(STACK_DEPTH);

	typedef enum logic {ST_IDLE, ST_WRITE} state_t;

	state_t                      state_q;
	logic                        out_valid_q;
	logic                        ready_q;
	logic        [DW-1:0]        depth_q;
	err_t                        err_q;
	op_t                         op_s1;
	logic signed [VALUE_W-1:0]   push_s1;
	logic signed [2*VALUE_W-1:0] prod_s1;
	logic signed [VALUE_W-1:0]   pop_q;

	logic signed [VALUE_W-1:0] cell_val [STACK_DEPTH];
	cell_cmd_t                 cell0_cmd;
	cell_cmd_t                 rest_cmd;
	logic signed [VALUE_W-1:0] load_value;
	alu_out_t                  alu_res;

	logic                      do_write;
	logic                      next_ready;
	logic        [DW-1:0]      next_depth;
	err_t                      next_err;
	logic signed [VALUE_W-1:0] next_pop;
	logic                      is_push;

	logic [DW+OUT_DEPTH_W-1:0] depth_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign do_write = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	rsc_alu u_alu (
		.op   (op_s1),
		.a    (cell_val[0]),
		.b    (cell_val[1]),
		.prod (prod_s1),
		.res  (alu_res)
	);

	always_comb begin
		next_ready = ready_q;
		next_depth = depth_q;
		next_err   = err_q;
		next_pop   = '0;
		cell0_cmd  = CELL_HOLD;
		rest_cmd   = CELL_HOLD;
		is_push    = 1'b0;
		case (op_s1)
			OP_INIT: begin
				if (!ready_q) begin
					next_ready = 1'b1;
					next_depth = '0;
					next_err   = ERR_OK;
				end
			end
			OP_RELEASE: begin
				next_ready = 1'b0;
				next_depth = '0;
				next_err   = ERR_OK;
			end
			OP_PUSH: begin
				if (!ready_q) begin
					next_err = ERR_NOT_INIT;
				end else if (depth_q >= FULL_D) begin
					next_err = ERR_FULL;
				end else begin
					is_push    = 1'b1;
					cell0_cmd  = CELL_FROM_PREV;
					rest_cmd   = CELL_FROM_PREV;
					next_depth = depth_q + 1'b1;
				end
			end
			OP_ADD, OP_MULTIPLY: begin
				if (!ready_q) begin
					next_err = ERR_NOT_INIT;
				end else if (depth_q < DW'(2)) begin
					next_err = ERR_BINARY;
				end else begin
					// result lands in the top cell, the rest close the gap
					cell0_cmd  = CELL_FROM_PREV;
					rest_cmd   = CELL_FROM_NEXT;
					next_depth = depth_q - 1'b1;
					if (alu_res.ovf)
						next_err = ERR_OVERFLOW;
				end
			end
			OP_NEGATE: begin
				if (!ready_q) begin
					next_err = ERR_NOT_INIT;
				end else if (depth_q == '0) begin
					next_err = ERR_UNARY;
				end else begin
					cell0_cmd = CELL_FROM_PREV;
					if (alu_res.ovf)
						next_err = ERR_OVERFLOW;
				end
			end
			OP_POP: begin
				if (!ready_q) begin
					next_err = ERR_NOT_INIT;
				end else if (depth_q == '0) begin
					next_err = ERR_POP;
				end else begin
					cell0_cmd  = CELL_FROM_NEXT;
					rest_cmd   = CELL_FROM_NEXT;
					next_pop   = cell_val[0];
					next_depth = depth_q - 1'b1;
				end
			end
			default: begin
				next_err = err_q;
			end
		endcase
		if (!do_write) begin
			cell0_cmd = CELL_HOLD;
			rest_cmd  = CELL_HOLD;
		end
	end

	assign load_value = is_push ? push_s1 : alu_res.result;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_cmd_t                 cmd;
		logic signed [VALUE_W-1:0] prev_v;
		logic signed [VALUE_W-1:0] next_v;

		if (i == 0) begin : g_top
			assign cmd    = cell0_cmd;
			assign prev_v = load_value;
		end else begin : g_mid
			assign cmd    = rest_cmd;
			assign prev_v = cell_val[i-1];
		end

		// bottom cell has nothing below it; its own value stands in
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign next_v = cell_val[i];
		end else begin : g_inner
			assign next_v = cell_val[i+1];
		end

		rsc_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ready_q     <= 1'b0;
			depth_q     <= '0;
			err_q       <= ERR_OK;
		end else begin
			if (do_write)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (do_write) begin
						state_q <= ST_IDLE;
						ready_q <= next_ready;
						depth_q <= next_depth;
						err_q   <= next_err;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operands and product captured at the accepting edge
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_t'(req_type);
			push_s1 <= push_value;
			prod_s1 <= cell_val[0] * cell_val[1];
		end
		if (do_write)
			pop_q <= next_pop;
	end

	assign depth_ext   = {{OUT_DEPTH_W{1'b0}}, depth_q};
	assign out_valid   = out_valid_q;
	assign pop_value   = pop_q;
	assign error_code  = err_q;
	assign stack_depth = depth_ext[OUT_DEPTH_W-1:0];

endmodule

// ===== rtl/rsc_checker.sv =====
`include "assert_macros.svh"

module rsc_checker
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic        [OP_W-1:0]        req_type,
	input logic signed [VALUE_W-1:0]     push_value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [VALUE_W-1:0]     pop_value,
	input logic        [ERR_W-1:0]       error_code,
	input logic        [OUT_DEPTH_W-1:0] stack_depth
);

	logic in_beat;
	logic depth_ok;

	assign in_beat  = in_valid && in_ready;
	assign depth_ok = (STACK_DEPTH > 255) || (int'(stack_depth) <= STACK_DEPTH);

	// a stalled result holds
	`RSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pop_value) && $stable(error_code) && $stable(stack_depth))

	// one operation in flight at a time
	`RSC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_beat, !in_ready)

	// error code 7 is never produced
	`RSC_ASSERT_NOW(a_err_code, clk, arst_n, out_valid, error_code != 3'd7)

	// depth never passes the stack size (checked only for stacks of at most 255 entries)
	`RSC_ASSERT_NOW(a_depth_bound, clk, arst_n, out_valid, depth_ok)

endmodule

bind rpn_stack_calculator_unit rsc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rsc_checker (.*);
